### rtl/fed_pkg.sv
`default_nettype none

package fed_pkg;

    typedef enum logic [2:0] {
        CFG_WEIGHT_0 = 3'd0,
        CFG_WEIGHT_1 = 3'd1,
        CFG_WEIGHT_2 = 3'd2,
        CFG_WEIGHT_3 = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } cfg_index_t;

    localparam logic [15:0] WEIGHT_0_RST = 16'd6545;
    localparam logic [15:0] WEIGHT_1_RST = 16'd5236;
    localparam logic [15:0] WEIGHT_2_RST = 16'd4712;
    localparam logic [15:0] WEIGHT_3_RST = 16'd3142;
    localparam int          SIZE_RST     = 64;
    localparam logic [17:0] VALUE_MAX    = 18'd262143;

    typedef struct packed {
        logic [8:0] ox;
        logic [8:0] oy;
        logic       done;
    } meta_t;

endpackage

`default_nettype wire

### rtl/fed_line_mem.sv
`default_nettype none

module fed_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int PB    = 16
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [AW-1:0]        addr,
    input  wire logic [1:0]           lane,
    input  wire logic [PB-1:0]        wdata,
    output logic      [2:0][PB-1:0]   rdata
);

    logic [2:0][PB-1:0] mem [DEPTH];

    // read-first: the read returns the word before this write
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata <= mem[addr];
            mem[addr][lane] <= wdata;
        end
    end

endmodule

`default_nettype wire

### rtl/fed_rank_pipe.sv
`default_nettype none

module fed_rank_pipe
    import fed_pkg::*;
#(
    parameter int PB = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [3:0][3:0][PB-1:0]  grid,
    input  wire meta_t                    in_meta,
    input  wire logic [3:0][15:0]         weight,
    output logic                          advance,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [17:0]                   value,
    output logic [8:0]                    out_column,
    output logic [8:0]                    out_row,
    output logic                          frame_done
);

    localparam int PW = PB + 16;
    localparam int SW = PB + 18;
    localparam int TW = PB + 21;

    function automatic logic [2:0][PB-1:0] sort3(input logic [2:0][PB-1:0] x);
        logic [2:0][PB-1:0] y;
        logic [PB-1:0]      t;
        y = x;
        if (y[1] < y[0]) begin t = y[0]; y[0] = y[1]; y[1] = t; end
        if (y[2] < y[1]) begin t = y[1]; y[1] = y[2]; y[2] = t; end
        if (y[1] < y[0]) begin t = y[0]; y[0] = y[1]; y[1] = t; end
        return y;
    endfunction

    // four smallest of a sorted four and a sorted three
    function automatic logic [3:0][PB-1:0] merge4(input logic [3:0][PB-1:0] a,
                                                 input logic [2:0][PB-1:0] b);
        logic [2:0]         pa [4];
        logic [2:0]         pb [3];
        logic [3:0][PB-1:0] o;
        o = '0;
        for (int i = 0; i < 4; i++) pa[i] = 3'(i);
        for (int j = 0; j < 3; j++) pb[j] = 3'(j);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
                if (b[j] < a[i]) pa[i] = pa[i] + 3'd1;
                else             pb[j] = pb[j] + 3'd1;
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 4; i++) if (pa[i] == 3'(k)) o[k] = o[k] | a[i];
            for (int j = 0; j < 3; j++) if (pb[j] == 3'(k)) o[k] = o[k] | b[j];
        end
        return o;
    endfunction

    logic                       v_reg [5];
    meta_t                      m_reg [5];
    logic [3:0][2:0][2:0][PB-1:0] srt_reg;
    logic [3:0][3:0][PB-1:0]    m6_reg;
    logic [3:0][2:0][PB-1:0]    row2_reg;
    logic [3:0][3:0][PB-1:0]    m4_reg;
    logic [3:0][3:0][PW-1:0]    prod_reg;
    logic [3:0][SW-1:0]         sum_reg;
    logic [TW-1:0]              tot;
    logic [TW-17:0]             rnd;
    logic [17:0]                value_next;

    assign advance = !(out_valid && !out_ready && v_reg[4]);

    always_comb
    begin
        tot = TW'(sum_reg[0]) + TW'(sum_reg[1]) + TW'(sum_reg[2]) + TW'(sum_reg[3])
            + TW'(32768);
        rnd = tot[TW-1:16];
        value_next = (32'(rnd) > 32'(VALUE_MAX)) ? VALUE_MAX : 18'(rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 5; s++) v_reg[s] <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                v_reg[0] <= in_valid;
                for (int s = 1; s < 5; s++) v_reg[s] <= v_reg[s-1];
            end
            if (advance && v_reg[4]) out_valid <= 1'b1;
            else if (out_ready)      out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_reg[0] <= in_meta;
            for (int s = 1; s < 5; s++) m_reg[s] <= m_reg[s-1];
            for (int n = 0; n < 4; n++)
            begin
                for (int i = 0; i < 3; i++)
                    srt_reg[n][i] <= sort3({grid[n/2+i][n%2+2], grid[n/2+i][n%2+1],
                                            grid[n/2+i][n%2]});
                m6_reg[n]   <= merge4({{PB{1'b1}}, srt_reg[n][0]}, srt_reg[n][1]);
                row2_reg[n] <= srt_reg[n][2];
                m4_reg[n]   <= merge4(m6_reg[n], row2_reg[n]);
                for (int k = 0; k < 4; k++)
                    prod_reg[n][k] <= PW'(m4_reg[n][k]) * PW'(weight[k]);
                sum_reg[n] <= SW'(prod_reg[n][0]) + SW'(prod_reg[n][1])
                            + SW'(prod_reg[n][2]) + SW'(prod_reg[n][3]);
            end
            if (v_reg[4])
            begin
                value      <= value_next;
                out_column <= m_reg[4].ox;
                out_row    <= m_reg[4].oy;
                frame_done <= m_reg[4].done;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/fuzzy_erosion_downsample_unit.sv
// Fuzzy erosion with 2x2 downsampling.
// Source pixels enter on the in_valid/in_ready request channel in raster order,
// one per cycle at full rate. Each output sample leaves on out_valid/out_ready
// with its column, row and a frame_done flag on the last sample of the frame.
// An output is produced on the request that carries the bottom-right source
// pixel it depends on, then registered through the window and rank pipelines.
// Throughput is one pixel per cycle unless stalled, set by the single-port line
// memory that is read and written once per pixel, three rows wide in one word.
// Weights and image size are written on the cfg_valid/cfg_ready channel, which
// is always ready; write them only while the block is idle.
// Reset restores the default weights and a 64x64 size and restarts at the
// first pixel of a frame. The line memory needs no clearing.
// When the receiver stalls, the result waits in the output register; pixels are
// still taken until a finished result reaches the end of the pipeline, then
// in_ready drops until the output is taken.
`default_nettype none

module fuzzy_erosion_downsample_unit
    import fed_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] pixel,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [17:0]      value,
    output logic [8:0]       out_column,
    output logic [8:0]       out_row,
    output logic             frame_done
);

    localparam int PB = PIXEL_BITS;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [CW-1:0] W_RST = CW'((MAX_WIDTH < SIZE_RST) ? MAX_WIDTH : SIZE_RST);
    localparam logic [RW-1:0] H_RST = RW'((MAX_HEIGHT < SIZE_RST) ? MAX_HEIGHT : SIZE_RST);

    function automatic logic [CW-1:0] eff_w(input logic [10:0] v);
        logic [11:0] e;
        e = {1'b0, v[10:1], 1'b0};
        if (e < 12'd2) e = 12'd2;
        return (32'(e) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(e);
    endfunction

    function automatic logic [RW-1:0] eff_h(input logic [10:0] v);
        logic [11:0] e;
        e = {1'b0, v[10:1], 1'b0};
        if (e < 12'd2) e = 12'd2;
        return (32'(e) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(e);
    endfunction

    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    logic [3:0][15:0] weight_reg;
    logic [CW-1:0]    w_reg;
    logic [RW-1:0]    h_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [1:0]       slot_reg, slot_next;

    logic             advance;
    logic             accept;
    logic [PB-1:0]    p;
    logic [CW-1:0]    c;
    logic [RW-1:0]    r;
    logic [1:0]       s;
    logic [RW:0]      rt;
    logic [1:0]       st;
    logic [CW:0]      c1;
    logic [RW:0]      r1;
    logic             have_x, have_y;
    logic [CW-1:0]    ox, wm1x;
    logic [RW-1:0]    oy, hm1y;
    logic [CW:0]      tx;
    logic [RW:0]      ty;
    logic [CW-1:0]    xc;
    logic [RW-1:0]    yc;
    logic [1:0]       wc [4];
    logic [1:0]       wr [4];
    meta_t            meta;

    logic             v1_reg, e1_reg;
    meta_t            meta1_reg;
    logic [1:0]       wc1_reg [4];
    logic [1:0]       wr1_reg [4];
    logic [1:0]       slot1_reg;
    logic [PB-1:0]    p1_reg;
    logic [2:0][PB-1:0] rdata;
    logic [PB-1:0]    win_reg  [4][4];
    logic [PB-1:0]    win_next [4][4];
    logic [PB-1:0]    col_in [4];
    logic [3:0][3:0][PB-1:0] grid;

    assign cfg_ready = 1'b1;
    assign in_ready  = advance;
    assign accept    = in_valid && advance;
    assign p         = PB'(pixel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= {WEIGHT_3_RST, WEIGHT_2_RST, WEIGHT_1_RST, WEIGHT_0_RST};
            w_reg      <= W_RST;
            h_reg      <= H_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index) inside
                [CFG_WEIGHT_0:CFG_WEIGHT_3]: weight_reg[cfg_index[1:0]] <= cfg_data;
                CFG_WIDTH:                   w_reg <= eff_w(cfg_data[10:0]);
                CFG_HEIGHT:                  h_reg <= eff_h(cfg_data[10:0]);
                default:                     ;
            endcase
        end
    end

    // position of this pixel, next position, output decision and window taps
    always_comb
    begin
        if (col_reg >= w_reg)
        begin
            c  = '0;
            rt = (RW+1)'(row_reg) + (RW+1)'(1);
            st = slot_inc(slot_reg);
        end
        else
        begin
            c  = col_reg;
            rt = (RW+1)'(row_reg);
            st = slot_reg;
        end
        if (rt >= (RW+1)'(h_reg))
        begin
            r = '0;
            s = 2'd0;
        end
        else
        begin
            r = rt[RW-1:0];
            s = st;
        end

        c1 = (CW+1)'(c) + (CW+1)'(1);
        r1 = (RW+1)'(r) + (RW+1)'(1);
        if (c1 >= (CW+1)'(w_reg))
        begin
            col_next = '0;
            if (r1 >= (RW+1)'(h_reg))
            begin
                row_next  = '0;
                slot_next = 2'd0;
            end
            else
            begin
                row_next  = r1[RW-1:0];
                slot_next = slot_inc(s);
            end
        end
        else
        begin
            col_next  = c1[CW-1:0];
            row_next  = r;
            slot_next = s;
        end

        wm1x = (w_reg >> 1) - CW'(1);
        hm1y = (h_reg >> 1) - RW'(1);
        have_x = 1'b0;
        ox     = '0;
        if (c >= CW'(2) && !c[0])
        begin
            have_x = 1'b1;
            ox     = (c >> 1) - CW'(1);
        end
        else if (c == w_reg - CW'(1))
        begin
            have_x = 1'b1;
            ox     = wm1x;
        end
        have_y = 1'b0;
        oy     = '0;
        if (r >= RW'(2) && !r[0])
        begin
            have_y = 1'b1;
            oy     = (r >> 1) - RW'(1);
        end
        else if (r == h_reg - RW'(1))
        begin
            have_y = 1'b1;
            oy     = hm1y;
        end

        tx = '0;
        ty = '0;
        xc = '0;
        yc = '0;
        for (int m = 0; m < 4; m++)
        begin
            tx = (CW+1)'({ox, 1'b0}) + (CW+1)'(m);
            if (tx == '0)                             xc = '0;
            else if (tx - (CW+1)'(1) > (CW+1)'(w_reg - CW'(1))) xc = w_reg - CW'(1);
            else                                      xc = CW'(tx - (CW+1)'(1));
            wc[m] = xc[1:0] + 2'd3 - c[1:0];
            ty = (RW+1)'({oy, 1'b0}) + (RW+1)'(m);
            if (ty == '0)                             yc = '0;
            else if (ty - (RW+1)'(1) > (RW+1)'(h_reg - RW'(1))) yc = h_reg - RW'(1);
            else                                      yc = RW'(ty - (RW+1)'(1));
            wr[m] = yc[1:0] + 2'd3 - r[1:0];
        end

        meta.ox   = 9'(ox);
        meta.oy   = 9'(oy);
        meta.done = (ox == wm1x) && (oy == hm1y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= 2'd0;
            v1_reg   <= 1'b0;
            e1_reg   <= 1'b0;
            for (int k = 0; k < 4; k++)
                for (int j = 0; j < 4; j++)
                    win_reg[k][j] <= '0;
        end
        else if (advance)
        begin
            v1_reg <= accept;
            e1_reg <= accept && have_x && have_y;
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
            if (v1_reg)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta1_reg <= meta;
            wc1_reg   <= wc;
            wr1_reg   <= wr;
            slot1_reg <= s;
            p1_reg    <= p;
        end
    end

    fed_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .PB    (PB)
    ) u_line_mem (
        .clk   (clk),
        .en    (accept),
        .addr  (AW'(c)),
        .lane  (s),
        .wdata (p),
        .rdata (rdata)
    );

    // lanes in row order: oldest row first, current pixel last
    always_comb
    begin
        case (slot1_reg)
            2'd0:    begin col_in[0] = rdata[0]; col_in[1] = rdata[1]; col_in[2] = rdata[2]; end
            2'd1:    begin col_in[0] = rdata[1]; col_in[1] = rdata[2]; col_in[2] = rdata[0]; end
            default: begin col_in[0] = rdata[2]; col_in[1] = rdata[0]; col_in[2] = rdata[1]; end
        endcase
        col_in[3] = p1_reg;
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 3; j++)
                win_next[k][j] = win_reg[k][j+1];
            win_next[k][3] = col_in[k];
        end
        for (int k = 0; k < 4; k++)
            for (int m = 0; m < 4; m++)
                grid[k][m] = win_next[wr1_reg[k]][wc1_reg[m]];
    end

    fed_rank_pipe #(
        .PB (PB)
    ) u_rank_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v1_reg && e1_reg),
        .grid       (grid),
        .in_meta    (meta1_reg),
        .weight     (weight_reg),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .out_column (out_column),
        .out_row    (out_row),
        .frame_done (frame_done)
    );

endmodule

`default_nettype wire
